// ----- rtl/core/vic_pkg.sv -----
// Package for the vectored interrupt controller core.
// Holds the request/response payload types and the function codes.
// No dependencies.
package vic_pkg;

    localparam int SOURCE_W     = 8;
    localparam int OUT_SOURCE_W = 7;
    localparam int FUNC_W       = 3;
    localparam int VEC_W        = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENABLE  = 3'd0,
        FN_DISABLE = 3'd1,
        FN_SETVEC  = 3'd2,
        FN_RAISE   = 3'd3,
        FN_LOWER   = 3'd4
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SOURCE_W-1:0] source;
        logic [VEC_W-1:0]    vector;
    } req_t;

    typedef struct packed {
        logic                    pending_valid;
        logic [OUT_SOURCE_W-1:0] pending_source;
        logic [VEC_W-1:0]        pending_vector;
        logic                    rejected;
    } rsp_t;

endpackage

// ----- rtl/core/vic_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// No dependencies.
module vic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/vectored_interrupt_controller_core.sv -----
// Vectored interrupt controller core: enable/line flops, banked priority
// encode and a vector RAM. Depends on vic_pkg and vic_ram.
//
//  channel   ports              handshake
//  request   start, busy, req   taken when start && !busy (busy is always low)
//  result    done, rsp          one cycle per request, no backpressure
//
// A request may be issued every cycle; its result goes up on done/rsp after
// these registered steps, in order: flop update, bank encode, vector RAM read.
// Reset (rst_n low) clears enables, line levels and the vector valid bits;
// vector entries never written read as zero.
// The receiver cannot stall; results are not buffered.
module vectored_interrupt_controller_core #(
    parameter int SOURCES     = 128,
    parameter int BANK_SIZE   = 32,
    parameter int VECTOR_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vic_pkg::req_t req,
    output logic          done,
    output vic_pkg::rsp_t rsp
);

    import vic_pkg::*;

    localparam int SRC_W  = $clog2(SOURCES);
    localparam int NB     = (SOURCES + BANK_SIZE - 1) / BANK_SIZE;
    localparam int BIDX_W = $clog2(BANK_SIZE);

    logic               accept;
    logic               single;
    logic [SRC_W-1:0]   s_idx;
    logic               set_rej;

    logic [SOURCES-1:0] en_reg, en_next;
    logic [SOURCES-1:0] line_reg, line_next;
    logic [SOURCES-1:0] vv_reg;

    // stage 1: pending vector write, request tag
    logic                   p1_valid_reg;
    logic                   p1_rej_reg;
    logic                   wr_en_reg, wr_en_next;
    logic [SRC_W-1:0]       wr_addr_reg;
    logic [VECTOR_BITS-1:0] wr_data_reg;
    logic [63:0]            vec_wide;

    // stage 2: per-bank winners
    logic              p2_valid_reg;
    logic              p2_rej_reg;
    logic [NB-1:0]     bank_hit, bank_hit_reg;
    logic [BIDX_W-1:0] bank_idx [NB];
    logic [BIDX_W-1:0] bank_idx_reg [NB];
    logic              win_hit;
    logic [SRC_W-1:0]  win_src;

    // stage 3: result
    logic                   p3_valid_reg;
    logic                   p3_rej_reg;
    logic                   p3_hit_reg;
    logic [SRC_W-1:0]       p3_src_reg;
    logic                   p3_vv_reg;
    logic [VECTOR_BITS-1:0] rd_data;
    logic [63:0]            rd_wide;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign single  = req.source < SOURCE_W'(SOURCES);
    assign s_idx   = req.source[SRC_W-1:0];
    assign vec_wide = {32'b0, req.vector};

    always_comb
    begin
        en_next    = en_reg;
        line_next  = line_reg;
        wr_en_next = 1'b0;
        set_rej    = 1'b0;
        case (func_t'(req.func))
            FN_ENABLE:
            begin
                if (single)
                    en_next[s_idx] = 1'b1;
                else
                    en_next = '1;
            end
            FN_DISABLE:
            begin
                if (single)
                    en_next[s_idx] = 1'b0;
                else
                    en_next = '0;
            end
            FN_SETVEC:
            begin
                wr_en_next = single;
                set_rej    = !single;
            end
            FN_RAISE:
            begin
                if (single)
                    line_next[s_idx] = 1'b1;
            end
            FN_LOWER:
            begin
                if (single)
                    line_next[s_idx] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= '0;
            line_reg     <= '0;
            p1_valid_reg <= 1'b0;
            p1_rej_reg   <= 1'b0;
            wr_en_reg    <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p1_rej_reg   <= accept && set_rej;
            wr_en_reg    <= accept && wr_en_next;
            if (accept)
            begin
                en_reg   <= en_next;
                line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_addr_reg <= s_idx;
            wr_data_reg <= vec_wide[VECTOR_BITS-1:0];
        end
    end

    // Lowest set bit of enable & line within each bank.
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            bank_hit[b] = 1'b0;
            bank_idx[b] = '0;
            for (int k = BANK_SIZE - 1; k >= 0; k--)
            begin
                if (b * BANK_SIZE + k < SOURCES)
                begin
                    if (en_reg[b * BANK_SIZE + k] && line_reg[b * BANK_SIZE + k])
                    begin
                        bank_hit[b] = 1'b1;
                        bank_idx[b] = BIDX_W'(k);
                    end
                end
            end
        end
    end

    // Vector RAM write lands with the bank encode, so the read in the next
    // cycle sees exactly the writes up to the same request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg       <= '0;
            p2_valid_reg <= 1'b0;
            p2_rej_reg   <= 1'b0;
            bank_hit_reg <= '0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
            p2_rej_reg   <= p1_rej_reg;
            bank_hit_reg <= bank_hit;
            if (wr_en_reg)
                vv_reg[wr_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NB; b++)
            bank_idx_reg[b] <= bank_idx[b];
    end

    // Lowest bank with a hit wins.
    always_comb
    begin
        win_hit = 1'b0;
        win_src = '0;
        for (int b = NB - 1; b >= 0; b--)
        begin
            if (bank_hit_reg[b])
            begin
                win_hit = 1'b1;
                win_src = SRC_W'(b * BANK_SIZE) + SRC_W'(bank_idx_reg[b]);
            end
        end
    end

    vic_ram #(
        .WIDTH (VECTOR_BITS),
        .DEPTH (SOURCES)
    ) u_vec_ram (
        .clk   (clk),
        .we    (wr_en_reg),
        .waddr (wr_addr_reg),
        .wdata (wr_data_reg),
        .re    (p2_valid_reg && win_hit),
        .raddr (win_src),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
            p3_rej_reg   <= 1'b0;
            p3_hit_reg   <= 1'b0;
        end
        else
        begin
            p3_valid_reg <= p2_valid_reg;
            p3_rej_reg   <= p2_rej_reg;
            p3_hit_reg   <= win_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        p3_src_reg <= win_src;
        p3_vv_reg  <= vv_reg[win_src];
    end

    assign rd_wide = 64'(rd_data);

    assign done               = p3_valid_reg;
    assign rsp.pending_valid  = p3_hit_reg;
    assign rsp.pending_source = p3_hit_reg ? OUT_SOURCE_W'(p3_src_reg) : '0;
    assign rsp.pending_vector = (p3_hit_reg && p3_vv_reg) ? rd_wide[VEC_W-1:0] : '0;
    assign rsp.rejected       = p3_rej_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept && rst_n, 3))
        else $error("result strobe not three cycles after request");

    a_rej_from_setvec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.rejected) |-> ($past(req.func, 3) == FN_SETVEC))
        else $error("rejected result without a vector write request");

    a_rej_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.rejected |-> done)
        else $error("rejected flag outside a result cycle");

    a_win_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_hit |-> (win_src < SRC_W'(SOURCES - 1) || win_src == SRC_W'(SOURCES - 1)))
        else $error("priority winner beyond last source");

endmodule

// ----- sim/vic_response_check.sv -----
// Response checker for the vectored interrupt controller core.
// Predicts every result from the accepted requests and compares field by field.
// Depends on vic_pkg.
module vic_response_check #(
    parameter int SOURCES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  vic_pkg::req_t req,
    input  logic          done,
    input  vic_pkg::rsp_t rsp,
    output int            errors,
    output int            outstanding,
    output int            results_seen,
    output int            hits,
    output int            refusals
);

    import vic_pkg::*;

    bit [SOURCES-1:0] irq_enable;
    bit [SOURCES-1:0] irq_level;
    logic [VEC_W-1:0] handler [SOURCES];
    rsp_t             expected_status [$];
    int               mismatch_count;
    int               seen_count;
    int               hit_count;
    int               refused_count;

    // Applies one request to the model state and returns the status it leaves.
    function automatic rsp_t apply_request(req_t r);
        rsp_t   e;
        bit     whole;
        int     s;
        int     i;
        e     = '0;
        whole = (r.source >= SOURCES);
        s     = whole ? 0 : int'(r.source);
        case (r.func)
            FN_ENABLE:
            begin
                if (whole) irq_enable = '1;
                else irq_enable[s] = 1'b1;
            end
            FN_DISABLE:
            begin
                if (whole) irq_enable = '0;
                else irq_enable[s] = 1'b0;
            end
            FN_SETVEC:
            begin
                if (whole) e.rejected = 1'b1;
                else handler[s] = r.vector;
            end
            FN_RAISE:
            begin
                if (!whole) irq_level[s] = 1'b1;
            end
            FN_LOWER:
            begin
                if (!whole) irq_level[s] = 1'b0;
            end
            default:
            begin
            end
        endcase
        // banks are scanned in ascending order, so a flat scan from 0 matches
        for (i = 0; i < SOURCES; i++)
        begin
            if (!e.pending_valid && irq_enable[i] && irq_level[i])
            begin
                e.pending_valid  = 1'b1;
                e.pending_source = i[OUT_SOURCE_W-1:0];
                e.pending_vector = handler[i];
            end
        end
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int   i;
        rsp_t e;
        bit   bad;
        if (!rst_n)
        begin
            irq_enable = '0;
            irq_level  = '0;
            for (i = 0; i < SOURCES; i++)
                handler[i] = '0;
            expected_status.delete();
            mismatch_count = 0;
            seen_count     = 0;
            hit_count      = 0;
            refused_count  = 0;
        end
        else
        begin
            if (start && !busy)
                expected_status.push_back(apply_request(req));
            if (done)
            begin
                seen_count++;
                if (rsp.pending_valid === 1'b1) hit_count++;
                if (rsp.rejected === 1'b1) refused_count++;
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("vic check: result %0d arrived with no request waiting",
                                 seen_count);
                end
                else
                begin
                    e   = expected_status.pop_front();
                    bad = (rsp.pending_valid  !== e.pending_valid)  ||
                          (rsp.pending_source !== e.pending_source) ||
                          (rsp.pending_vector !== e.pending_vector) ||
                          (rsp.rejected       !== e.rejected);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"vic check: result %0d wrong: expected valid=%0b ",
                                      "src=%0d vec=%08h rej=%0b, got valid=%0b src=%0d ",
                                      "vec=%08h rej=%0b"},
                                     seen_count, e.pending_valid, e.pending_source,
                                     e.pending_vector, e.rejected, rsp.pending_valid,
                                     rsp.pending_source, rsp.pending_vector, rsp.rejected);
                    end
                end
            end
        end
        errors       <= mismatch_count;
        outstanding  <= expected_status.size();
        results_seen <= seen_count;
        hits         <= hit_count;
        refusals     <= refused_count;
    end

endmodule

// ----- sim/tb_vectored_interrupt_controller_core.sv -----
// Top-level testbench for vectored_interrupt_controller_core.
// Drives directed and random requests; vic_response_check predicts and compares.
// Depends on vic_pkg, vic_response_check and the core RTL.
module tb_vectored_interrupt_controller_core;
    import vic_pkg::*;

    localparam int SOURCES        = 128;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [SOURCE_W-1:0] ALL_SOURCES = 8'd128;
    // function codes the block does not define
    localparam logic [FUNC_W-1:0] FN_SPARE5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    int errors;
    int outstanding;
    int results_seen;
    int hits;
    int refusals;
    int sent       = 0;
    int directed   = 0;
    int quiet_cycles = 0;
    bit no_idle    = 1'b0;
    int hot_bases [8] = '{0, 24, 32, 60, 64, 90, 96, 116};

    vectored_interrupt_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    vic_response_check #(
        .SOURCES (SOURCES)
    ) rsp_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .done         (done),
        .rsp          (rsp),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .hits         (hits),
        .refusals     (refusals)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Issues one request after a random idle gap, or none if no_idle is set;
    // returns at the falling edge after it was taken, with start still high.
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [SOURCE_W-1:0] s,
                         input logic [VEC_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.func   = f;
        req.source = s;
        req.vector = v;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic [SOURCE_W-1:0] pick_source(int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return {1'b0, 7'(base + $urandom_range(0, 15))};
        else if (r < 75)
            return ALL_SOURCES;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return FN_ENABLE;
        if (r < 32) return FN_DISABLE;
        if (r < 52) return FN_SETVEC;
        if (r < 76) return FN_RAISE;
        if (r < 96) return FN_LOWER;
        case ($urandom_range(0, 2))
            0:       return FN_SPARE5;
            1:       return FN_SPARE6;
            default: return FN_SPARE7;
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] pick_vector();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    initial
    begin
        int phase;
        int base;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: bank edges, all-sources code, refused vector writes,
        // out-of-range line events, spare codes, nothing pending
        issue(FN_SPARE5,  8'd0,   32'h0000_0000);
        issue(FN_SETVEC,  8'd0,   32'hFFFF_FFFF);
        issue(FN_SETVEC,  8'd127, 32'h0000_0000);
        issue(FN_SETVEC,  8'd64,  32'hA5A5_5A5A);
        issue(FN_SETVEC,  ALL_SOURCES, 32'h1234_5678);
        issue(FN_SETVEC,  8'd255, 32'hFFFF_FFFF);
        issue(FN_RAISE,   8'd127, 32'h0);
        issue(FN_ENABLE,  8'd127, 32'h0);
        issue(FN_RAISE,   8'd0,   32'h0);
        issue(FN_ENABLE,  8'd0,   32'h0);
        issue(FN_LOWER,   8'd0,   32'h0);
        issue(FN_RAISE,   8'd64,  32'h0);
        issue(FN_ENABLE,  ALL_SOURCES, 32'h0);
        issue(FN_RAISE,   8'd200, 32'h0);
        issue(FN_LOWER,   8'd255, 32'h0);
        issue(FN_RAISE,   ALL_SOURCES, 32'h0);
        issue(FN_RAISE,   8'd31,  32'h0);
        issue(FN_RAISE,   8'd32,  32'h0);
        issue(FN_RAISE,   8'd96,  32'h0);
        issue(FN_DISABLE, 8'd31,  32'h0);
        issue(FN_SPARE6,  8'd31,  32'hFFFF_FFFF);
        issue(FN_SPARE7,  ALL_SOURCES, 32'hFFFF_FFFF);
        issue(FN_DISABLE, ALL_SOURCES, 32'h0);
        issue(FN_ENABLE,  8'd96,  32'h0);
        issue(FN_LOWER,   8'd96,  32'h0);
        directed = sent;

        // random: each phase works a window of sources near a bank edge
        for (phase = 0; phase < 17; phase++)
        begin
            base    = hot_bases[$urandom_range(0, 7)];
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (100)
                issue(pick_func(), pick_source(base), pick_vector());
        end
        start = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed); %0d results checked, %0d with a source",
                 sent, directed, results_seen, hits);
        $display("pending and %0d refused vector writes.", refusals);
        if (errors == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/vic_pkg.sv
rtl/core/vic_ram.sv
rtl/core/vectored_interrupt_controller_core.sv
sim/vic_response_check.sv
sim/tb_vectored_interrupt_controller_core.sv
